// ===== rtl/qgm_pkg.sv =====
// Shared types and constants of the group-quantized matrix-vector unit.
`default_nettype none
package qgm_pkg;

    localparam int MAX_ROW_LENGTH_DEF = 65535;
    localparam int MAX_GROUP_SIZE_DEF = 256;
    localparam int MIN_GROUP          = 16;

    localparam logic [15:0] ROW_LENGTH_RST = 16'd4096;
    localparam logic [8:0]  GROUP_SIZE_RST = 9'd64;
    localparam logic [15:0] START_ROW_RST  = 16'd0;
    localparam logic [16:0] END_ROW_RST    = 17'd1;

    localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [1:0] REG_GROUP_SIZE = 2'd1;
    localparam logic [1:0] REG_START_ROW  = 2'd2;
    localparam logic [1:0] REG_END_ROW    = 2'd3;

    localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;

    typedef struct packed {
        logic signed [7:0] act_value;
        logic signed [7:0] weight_value;
        logic [31:0]       act_scale;
        logic [31:0]       weight_scale;
    } t_in_item;

    typedef struct packed {
        logic [31:0] row_result;
        logic [15:0] row_index;
        logic        last_row;
    } t_out_item;

    typedef enum logic [1:0] {
        FOP_CVT = 2'd0,
        FOP_MUL = 2'd1,
        FOP_ADD = 2'd2
    } t_fpu_op;

    typedef struct packed {
        logic        start;
        t_fpu_op     op;
        logic [31:0] a;
        logic [31:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] result;
    } t_fpu_rsp;

endpackage
`default_nettype wire

// ===== rtl/qgm_fpu.sv =====
// Iterative fp32 unit: int32 convert, multiply and add with round-to-nearest-even.
`default_nettype none
module qgm_fpu (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  qgm_pkg::t_fpu_req    i_req,
    output qgm_pkg::t_fpu_rsp    o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_NORM  = 2'd1,
        S_ROUND = 2'd2
    } t_state;

    t_state             r_state;
    logic [49:0]        r_m;
    logic signed [10:0] r_e;
    logic               r_sign;
    logic               r_st;
    logic               r_done;
    logic [31:0]        r_res;

    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0]         ea_f, eb_f;
    logic signed [10:0] ea, eb;
    logic [23:0]        ma, mb;
    logic [47:0]        prod;
    logic [31:0]        mag;
    logic               a_big;
    logic [7:0]         d_raw;
    logic signed [10:0] e_big;
    logic [49:0]        m_big, m_small, m_sh, sh_mask, m_sum;
    logic               sh_st;
    logic               s_big;

    logic               rnd_inc;
    logic [24:0]        rnd;
    logic signed [10:0] ef;
    logic [22:0]        frac;

    assign ea_f   = i_req.a[30:23];
    assign eb_f   = i_req.b[30:23];
    assign a_nan  = (ea_f == 8'hFF) && (i_req.a[22:0] != 23'd0);
    assign b_nan  = (eb_f == 8'hFF) && (i_req.b[22:0] != 23'd0);
    assign a_inf  = (ea_f == 8'hFF) && (i_req.a[22:0] == 23'd0);
    assign b_inf  = (eb_f == 8'hFF) && (i_req.b[22:0] == 23'd0);
    assign a_zero = (i_req.a[30:0] == 31'd0);
    assign b_zero = (i_req.b[30:0] == 31'd0);
    assign ea     = (ea_f == 8'd0) ? 11'sd1 : $signed({3'b000, ea_f});
    assign eb     = (eb_f == 8'd0) ? 11'sd1 : $signed({3'b000, eb_f});
    assign ma     = {(ea_f != 8'd0), i_req.a[22:0]};
    assign mb     = {(eb_f != 8'd0), i_req.b[22:0]};
    assign prod   = ma * mb;
    assign mag    = i_req.a[31] ? (32'd0 - i_req.a) : i_req.a;

    assign a_big   = (i_req.a[30:0] >= i_req.b[30:0]);
    assign e_big   = a_big ? ea : eb;
    assign s_big   = a_big ? i_req.a[31] : i_req.b[31];
    assign d_raw   = 8'(a_big ? (ea - eb) : (eb - ea));
    assign m_big   = {1'b0, (a_big ? ma : mb), 25'd0};
    assign m_small = {1'b0, (a_big ? mb : ma), 25'd0};
    assign sh_mask = (d_raw >= 8'd50) ? {50{1'b1}} : ((50'd1 << d_raw) - 50'd1);
    assign sh_st   = |(m_small & sh_mask);
    always_comb begin
        m_sh = (d_raw >= 8'd50) ? 50'd0 : (m_small >> d_raw);
        m_sh[0] = m_sh[0] | sh_st;
        if (i_req.a[31] == i_req.b[31]) begin
            m_sum = m_big + m_sh;
        end else begin
            m_sum = m_big - m_sh;
        end
    end

    assign rnd_inc = r_m[25] & (r_m[26] | r_st | (|r_m[24:0]));
    assign rnd     = {1'b0, r_m[49:26]} + {24'd0, rnd_inc};
    always_comb begin
        if (rnd[24]) begin
            ef   = r_e + 11'sd1;
            frac = 23'd0;
        end else if (rnd[23]) begin
            ef   = r_e;
            frac = rnd[22:0];
        end else begin
            ef   = 11'sd0;
            frac = rnd[22:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_st    <= 1'b0;
                        r_state <= S_NORM;
                        case (i_req.op)
                            qgm_pkg::FOP_CVT: begin
                                r_sign <= i_req.a[31];
                                r_m    <= {mag, 18'd0};
                                r_e    <= 11'sd158;
                            end
                            qgm_pkg::FOP_MUL: begin
                                r_sign <= i_req.a[31] ^ i_req.b[31];
                                r_m    <= {prod, 2'b00};
                                r_e    <= ea + eb - 11'sd126;
                                if (a_nan || b_nan || a_inf || b_inf) begin
                                    r_done  <= 1'b1;
                                    r_state <= S_IDLE;
                                    if (a_nan) begin
                                        r_res <= i_req.a | 32'h0040_0000;
                                    end else if (b_nan) begin
                                        r_res <= i_req.b | 32'h0040_0000;
                                    end else if (a_zero || b_zero) begin
                                        r_res <= qgm_pkg::FP_DEFAULT_NAN;
                                    end else begin
                                        r_res <= {i_req.a[31] ^ i_req.b[31], 8'hFF, 23'd0};
                                    end
                                end
                            end
                            qgm_pkg::FOP_ADD: begin
                                r_sign <= (m_sum == 50'd0) ? (i_req.a[31] & i_req.b[31])
                                                           : s_big;
                                r_m    <= m_sum;
                                r_e    <= e_big + 11'sd1;
                                if (a_nan || b_nan || a_inf || b_inf) begin
                                    r_done  <= 1'b1;
                                    r_state <= S_IDLE;
                                    if (a_nan) begin
                                        r_res <= i_req.a | 32'h0040_0000;
                                    end else if (b_nan) begin
                                        r_res <= i_req.b | 32'h0040_0000;
                                    end else if (a_inf && b_inf
                                                 && (i_req.a[31] != i_req.b[31])) begin
                                        r_res <= qgm_pkg::FP_DEFAULT_NAN;
                                    end else if (a_inf) begin
                                        r_res <= i_req.a;
                                    end else begin
                                        r_res <= i_req.b;
                                    end
                                end
                            end
                            default: begin
                                r_done  <= 1'b1;
                                r_res   <= qgm_pkg::FP_DEFAULT_NAN;
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_NORM: begin
                    if (r_m == 50'd0) begin
                        r_e     <= 11'sd1;
                        r_state <= S_ROUND;
                    end else if (r_e < 11'sd1) begin
                        if (r_e < -11'sd52) begin
                            r_st <= 1'b1;
                            r_m  <= 50'd0;
                            r_e  <= 11'sd1;
                        end else begin
                            r_st <= r_st | r_m[0];
                            r_m  <= r_m >> 1;
                            r_e  <= r_e + 11'sd1;
                        end
                    end else if (!r_m[49] && (r_e > 11'sd1)) begin
                        r_m <= r_m << 1;
                        r_e <= r_e - 11'sd1;
                    end else begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                    if (ef >= 11'sd255) begin
                        r_res <= {r_sign, 8'hFF, 23'd0};
                    end else begin
                        r_res <= {r_sign, ef[7:0], frac};
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.busy   = (r_state != S_IDLE);
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule
`default_nettype wire

// ===== rtl/q8_group_quantized_matvec_unit.sv =====
// Top level of the group-quantized int8 matrix-vector product unit.
// One request carries an int8 activation, an int8 weight and the fp32 scales of
// the current group. A request that does not close a quantization group is taken
// while the unit is idle and summed exactly. The request that closes a group
// starts four operations in turn on one shared iterative fp32 unit (convert, two
// multiplies, add); each lasts longer with each normalizing shift, an infinite
// or NaN operand ends a multiply or add early, and no request is taken until the
// add is done. A finished row waits in an output register; the row-end request
// also passes an emit state that takes no request. Writing any register restarts
// the job. Elements past the last full group of a row are taken and ignored.
`default_nettype none
module q8_group_quantized_matvec_unit #(
    parameter int MAX_ROW_LENGTH = qgm_pkg::MAX_ROW_LENGTH_DEF,
    parameter int MAX_GROUP_SIZE = qgm_pkg::MAX_GROUP_SIZE_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  qgm_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output qgm_pkg::t_out_item  o_out_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [3:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int RPW = $clog2(MAX_ROW_LENGTH + 1);
    localparam int GPW = $clog2(MAX_GROUP_SIZE + 1);

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_ISSUE = 2'd1,
        S_WAIT  = 2'd2,
        S_EMIT  = 2'd3
    } t_state;

    t_state           r_state;
    logic [15:0]      r_row_length;
    logic [8:0]       r_group_size;
    logic [15:0]      r_start_row;
    logic [16:0]      r_end_row;
    logic [31:0]      r_sum;
    logic [31:0]      r_acc;
    logic [GPW-1:0]   r_gpos;
    logic [RPW-1:0]   r_rpos;
    logic [15:0]      r_row;
    logic [1:0]       r_step;
    logic [31:0]      r_opnd;
    logic [31:0]      r_xs;
    logic [31:0]      r_ws;
    logic             r_row_end;
    logic             r_out_valid;
    qgm_pkg::t_out_item r_out;

    logic [RPW-1:0]   len;
    logic [GPW-1:0]   gs;
    logic             accept;
    logic             active;
    logic [15:0]      prod;
    logic [31:0]      n_sum;
    logic [GPW-1:0]   n_gpos;
    logic [RPW-1:0]   n_rpos;
    logic             grp_end;
    logic             row_end;
    logic             cfg_wr;
    logic             out_free;
    logic             last;
    qgm_pkg::t_fpu_req fpu_req;
    qgm_pkg::t_fpu_rsp fpu_rsp;

    always_comb begin
        if (r_row_length == 16'd0) begin
            len = RPW'(1);
        end else if (32'(r_row_length) > 32'(MAX_ROW_LENGTH)) begin
            len = RPW'(MAX_ROW_LENGTH);
        end else begin
            len = RPW'(r_row_length);
        end
        if (32'(r_group_size) < 32'(qgm_pkg::MIN_GROUP)) begin
            gs = GPW'(qgm_pkg::MIN_GROUP);
        end else if (32'(r_group_size) > 32'(MAX_GROUP_SIZE)) begin
            gs = GPW'(MAX_GROUP_SIZE);
        end else begin
            gs = GPW'(r_group_size);
        end
    end

    assign accept  = i_in_valid && (r_state == S_IDLE);
    assign active  = (r_gpos != '0) || ((32'(len) - 32'(r_rpos)) >= 32'(gs));
    assign prod    = 16'(i_in_data.act_value * i_in_data.weight_value);
    assign n_sum   = r_sum + {{16{prod[15]}}, prod};
    assign n_gpos  = r_gpos + GPW'(1);
    assign n_rpos  = r_rpos + RPW'(1);
    assign grp_end = active && (n_gpos == gs);
    assign row_end = (n_rpos == len);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign out_free = !r_out_valid || !i_out_stall;
    assign last    = ({1'b0, r_row} + 17'd1) >= r_end_row;

    always_comb begin
        fpu_req.start = (r_state == S_ISSUE);
        case (r_step)
            2'd0: begin
                fpu_req.op = qgm_pkg::FOP_CVT;
                fpu_req.a  = r_sum;
                fpu_req.b  = 32'd0;
            end
            2'd1: begin
                fpu_req.op = qgm_pkg::FOP_MUL;
                fpu_req.a  = r_opnd;
                fpu_req.b  = r_ws;
            end
            2'd2: begin
                fpu_req.op = qgm_pkg::FOP_MUL;
                fpu_req.a  = r_opnd;
                fpu_req.b  = r_xs;
            end
            default: begin
                fpu_req.op = qgm_pkg::FOP_ADD;
                fpu_req.a  = r_acc;
                fpu_req.b  = r_opnd;
            end
        endcase
    end

    qgm_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_row_length <= qgm_pkg::ROW_LENGTH_RST;
            r_group_size <= qgm_pkg::GROUP_SIZE_RST;
            r_start_row  <= qgm_pkg::START_ROW_RST;
            r_end_row    <= qgm_pkg::END_ROW_RST;
            r_sum        <= 32'd0;
            r_acc        <= 32'd0;
            r_gpos       <= '0;
            r_rpos       <= '0;
            r_row        <= qgm_pkg::START_ROW_RST;
            r_step       <= 2'd0;
            r_row_end    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                case (paddr[3:2])
                    qgm_pkg::REG_ROW_LENGTH: r_row_length <= pwdata[15:0];
                    qgm_pkg::REG_GROUP_SIZE: r_group_size <= pwdata[8:0];
                    qgm_pkg::REG_START_ROW:  r_start_row  <= pwdata[15:0];
                    qgm_pkg::REG_END_ROW:    r_end_row    <= pwdata[16:0];
                    default: begin
                    end
                endcase
                r_sum  <= 32'd0;
                r_acc  <= 32'd0;
                r_gpos <= '0;
                r_rpos <= '0;
                r_row  <= (paddr[3:2] == qgm_pkg::REG_START_ROW) ? pwdata[15:0]
                                                                   : r_start_row;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (accept) begin
                            r_rpos    <= n_rpos;
                            r_row_end <= row_end;
                            if (active) begin
                                r_sum  <= n_sum;
                                r_gpos <= n_gpos;
                            end
                            if (grp_end) begin
                                r_sum   <= n_sum;
                                r_gpos  <= '0;
                                r_xs    <= i_in_data.act_scale;
                                r_ws    <= i_in_data.weight_scale;
                                r_step  <= 2'd0;
                                r_state <= S_ISSUE;
                            end else if (row_end) begin
                                r_state <= S_EMIT;
                            end
                        end
                    end
                    S_ISSUE: begin
                        r_state <= S_WAIT;
                    end
                    S_WAIT: begin
                        if (fpu_rsp.done) begin
                            r_opnd <= fpu_rsp.result;
                            if (r_step == 2'd3) begin
                                r_acc   <= fpu_rsp.result;
                                r_sum   <= 32'd0;
                                r_state <= r_row_end ? S_EMIT : S_IDLE;
                            end else begin
                                r_step  <= r_step + 2'd1;
                                r_state <= S_ISSUE;
                            end
                        end
                    end
                    S_EMIT: begin
                        if (out_free) begin
                            r_out_valid      <= 1'b1;
                            r_out.row_result <= r_acc;
                            r_out.row_index  <= r_row;
                            r_out.last_row   <= last;
                            r_acc            <= 32'd0;
                            r_sum            <= 32'd0;
                            r_gpos           <= '0;
                            r_rpos           <= '0;
                            r_row            <= last ? r_start_row : (r_row + 16'd1);
                            r_state          <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[3:2])
            qgm_pkg::REG_ROW_LENGTH: prdata = {16'd0, r_row_length};
            qgm_pkg::REG_GROUP_SIZE: prdata = {23'd0, r_group_size};
            qgm_pkg::REG_START_ROW:  prdata = {16'd0, r_start_row};
            qgm_pkg::REG_END_ROW:    prdata = {15'd0, r_end_row};
            default:                 prdata = 32'd0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_fpu_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fpu_req.start |-> !fpu_rsp.busy)
        else $error("fp unit started while busy");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("row result raised outside emit");

    a_gpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_gpos < gs))
        else $error("group position past group size");
`endif

endmodule
`default_nettype wire

// ===== tb/q8_group_quantized_matvec_unit_tb.sv =====
// Testbench of the group-quantized int8 matrix-vector unit: directed table, random jobs, fp32 predictor.
`default_nettype none
module q8_group_quantized_matvec_unit_tb;

    localparam int TARGET_ITEMS = 950;
    localparam int SETTLE_CYCLES = 260;
    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD = 300;
    localparam logic [31:0] FP_ONE = 32'h3F80_0000;
    localparam logic [31:0] FP_TWO = 32'h4000_0000;
    localparam logic [31:0] FP_MAX = 32'h7F7F_FFFF;
    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
    localparam int N_DIRECTED = 24;
    localparam int DIRECTED_SPLIT = 4;

    typedef struct {
        qgm_pkg::t_in_item  req;
        bit                 typed;
        qgm_pkg::t_out_item want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    qgm_pkg::t_in_item  in_data = '0;
    logic        out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    qgm_pkg::t_out_item o_out_data;
    logic [31:0] prdata;
    logic        pready;

    q8_group_quantized_matvec_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall), .i_in_data(in_data),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [15:0]        cfg_row_length = qgm_pkg::ROW_LENGTH_RST;
    logic [8:0]         cfg_group_size = qgm_pkg::GROUP_SIZE_RST;
    logic [15:0]        cfg_start_row = qgm_pkg::START_ROW_RST;
    logic [16:0]        cfg_end_row = qgm_pkg::END_ROW_RST;
    logic signed [31:0] group_sum = 0;
    logic [31:0]        row_acc = 0;
    int unsigned        group_pos = 0;
    int unsigned        row_pos = 0;
    logic [15:0]        cur_row = 0;

    qgm_pkg::t_out_item expected_rows[$];
    int errors = 0;
    int sent = 0;
    int burst_left = 0;
    bit hold_req = 1'b0;
    t_dir_row dir_rows[N_DIRECTED];

    function automatic real from_fp32(logic [31:0] f);
        real r;
        if (f[30:23] == 8'hFF)
            r = (f[22:0] != 0) ? $bitstoreal(64'h7FF8_0000_0000_0000)
                               : $bitstoreal(64'h7FF0_0000_0000_0000);
        else if (f[30:23] == 8'h00)
            r = real'(int'(f[22:0])) * (2.0 ** -149);
        else
            r = $bitstoreal({1'b0, 11'(int'(f[30:23]) + 896), f[22:0], 29'd0});
        return f[31] ? -r : r;
    endfunction

    function automatic logic [31:0] to_fp32(real r);
        logic [63:0] b;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic        s;
        int          et;
        int          sh;
        b = $realtobits(r);
        s = b[63];
        if (b[62:52] == 11'h7FF)
            return (b[51:0] != 0) ? FP_QNAN : {s, 8'hFF, 23'd0};
        if (b[62:52] == 11'h000)
            return {s, 31'd0};
        et = int'(b[62:52]) - 1023 + 127;
        m = {11'd0, 1'b1, b[51:0]};
        sh = (et >= 1) ? 29 : 30 - et;
        if (sh > 54)
            return {s, 31'd0};
        q = m >> sh;
        rem = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        if (et >= 1) begin
            if (q[24]) begin
                q = q >> 1;
                et++;
            end
            if (et >= 255)
                return {s, 8'hFF, 23'd0};
            return {s, et[7:0], q[22:0]};
        end
        return {s, q[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        return to_fp32(from_fp32(a) * from_fp32(b));
    endfunction

    function automatic bit is_nan(logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] != 0;
    endfunction

    task automatic restart_job();
        group_sum = 0;
        row_acc = 0;
        group_pos = 0;
        row_pos = 0;
        cur_row = cfg_start_row;
    endtask

    task automatic predict_row(input qgm_pkg::t_in_item it, output bit has_row,
                               output qgm_pkg::t_out_item row);
        int unsigned len;
        int unsigned gs;
        int unsigned full;
        logic [31:0] scaled;
        len = (cfg_row_length == 0) ? 1 : cfg_row_length;
        gs = cfg_group_size;
        if (gs < qgm_pkg::MIN_GROUP) gs = qgm_pkg::MIN_GROUP;
        if (gs > qgm_pkg::MAX_GROUP_SIZE_DEF) gs = qgm_pkg::MAX_GROUP_SIZE_DEF;
        full = (len / gs) * gs;
        has_row = 1'b0;
        row = '0;
        if (row_pos < full) begin
            group_sum = group_sum + 32'(int'(it.act_value) * int'(it.weight_value));
            group_pos++;
            if (group_pos >= gs) begin
                scaled = fp_mul(fp_mul(to_fp32(real'(group_sum)), it.weight_scale),
                                it.act_scale);
                row_acc = to_fp32(from_fp32(row_acc) + from_fp32(scaled));
                group_sum = 0;
                group_pos = 0;
            end
        end
        row_pos++;
        if (row_pos >= len) begin
            has_row = 1'b1;
            row.row_result = row_acc;
            row.row_index = cur_row;
            row.last_row = (17'(cur_row) + 17'd1) >= cfg_end_row;
            row_acc = 0;
            group_sum = 0;
            group_pos = 0;
            row_pos = 0;
            cur_row = row.last_row ? cfg_start_row : cur_row + 16'd1;
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            qgm_pkg::REG_ROW_LENGTH: cfg_row_length = value[15:0];
            qgm_pkg::REG_GROUP_SIZE: cfg_group_size = value[8:0];
            qgm_pkg::REG_START_ROW:  cfg_start_row = value[15:0];
            default:                 cfg_end_row = value[16:0];
        endcase
        restart_job();
    endtask

    task automatic set_job(input logic [31:0] rl, input logic [31:0] gs,
                           input logic [31:0] sr, input logic [31:0] er);
        in_valid <= 1'b0;
        wait (expected_rows.size() == 0);
        @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        apb_write(qgm_pkg::REG_ROW_LENGTH, rl);
        apb_write(qgm_pkg::REG_GROUP_SIZE, gs);
        apb_write(qgm_pkg::REG_START_ROW, sr);
        apb_write(qgm_pkg::REG_END_ROW, er);
        burst_left = 0;
    endtask

    task automatic offer(input qgm_pkg::t_in_item it, input bit typed,
                         input qgm_pkg::t_out_item want);
        bit                 has_row;
        qgm_pkg::t_out_item row;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
        burst_left--;
        in_data <= it;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_row(it, has_row, row);
        if (has_row)
            expected_rows.push_back(typed ? want : row);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_scale();
        logic [31:0] f;
        case ($urandom_range(0, 15))
            0:       f = {$urandom_range(0, 1) == 1, 31'd0};
            1:       f = {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
            2:       f = {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 8388607))};
            3:       f = {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom())};
            4:       f = $urandom();
            default: f = {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 150)),
                          23'($urandom())};
        endcase
        return f;
    endfunction

    function automatic qgm_pkg::t_in_item rand_item();
        qgm_pkg::t_in_item it;
        it.act_value = 8'($urandom());
        it.weight_value = 8'($urandom());
        it.act_scale = rand_scale();
        it.weight_scale = rand_scale();
        return it;
    endfunction

    function automatic qgm_pkg::t_in_item mk(logic [7:0] a, logic [7:0] w, logic [31:0] xs,
                                             logic [31:0] ws);
        qgm_pkg::t_in_item it;
        it.act_value = a;
        it.weight_value = w;
        it.act_scale = xs;
        it.weight_scale = ws;
        return it;
    endfunction

    // receiver stall pattern and the one long hold-off
    initial begin
        int mode;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(16, 96)) begin
                @(negedge i_clk);
                if (hold_req) begin
                    out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(negedge i_clk);
                    hold_req = 1'b0;
                end else if (mode == 0) begin
                    out_stall <= 1'b0;
                end else if (mode == 1) begin
                    out_stall <= ($urandom_range(0, 3) == 0);
                end else begin
                    out_stall <= ($urandom_range(0, 3) != 0);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        qgm_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_rows.size() == 0) begin
                errors++;
                $display("%0t: unexpected row result %h", $time, o_out_data);
            end else begin
                want = expected_rows.pop_front();
                if (o_out_data.row_result !== want.row_result
                        && !(is_nan(want.row_result) && is_nan(o_out_data.row_result))) begin
                    errors++;
                    $display("%0t: row_result expected %h actual %h", $time,
                             want.row_result, o_out_data.row_result);
                end
                if (o_out_data.row_index !== want.row_index) begin
                    errors++;
                    $display("%0t: row_index expected %0d actual %0d", $time,
                             want.row_index, o_out_data.row_index);
                end
                if (o_out_data.last_row !== want.last_row) begin
                    errors++;
                    $display("%0t: last_row expected %b actual %b", $time,
                             want.last_row, o_out_data.last_row);
                end
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("q8_group_quantized_matvec_unit_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int                 n;
        int                 phase;
        logic [31:0]        rl;
        logic [31:0]        gs;
        logic [31:0]        sr;
        logic [31:0]        er;
        qgm_pkg::t_out_item none;
        none = '0;

        // short rows that yield +0.0 at once, on an inverted job
        for (int i = 0; i < DIRECTED_SPLIT; i++) begin
            dir_rows[i].typed = 1'b1;
            dir_rows[i].want = '{row_result: 32'h0, row_index: 16'hFFFF, last_row: 1'b1};
        end
        dir_rows[0].req = mk(8'h80, 8'h80, FP_ONE, FP_ONE);
        dir_rows[1].req = mk(8'h7F, 8'h80, FP_MAX, FP_MAX);
        dir_rows[2].req = mk(8'h00, 8'hFF, 32'h0, 32'hFFFF_FFFF);
        dir_rows[3].req = mk(8'hFF, 8'h7F, FP_QNAN, 32'h8000_0001);
        // one full group of extreme products, scaled into overflow, then a tail
        for (int i = DIRECTED_SPLIT; i < N_DIRECTED; i++) begin
            dir_rows[i].typed = 1'b0;
            dir_rows[i].want = none;
            dir_rows[i].req = mk((i % 2) ? 8'h80 : 8'h7F, 8'h80, FP_QNAN, FP_QNAN);
        end
        dir_rows[DIRECTED_SPLIT + 15].req = mk(8'h80, 8'h80, FP_TWO, FP_MAX);
        dir_rows[DIRECTED_SPLIT + 16].req = mk(8'h7F, 8'h7F, FP_ONE, 32'h0000_0001);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_job(32'd0, 32'd0, 32'd65535, 32'd0);
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (i == DIRECTED_SPLIT)
                set_job(32'd16, 32'd0, 32'd65534, 32'd65536);
            offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        end

        phase = 0;
        while (sent < TARGET_ITEMS) begin
            gs = 32'd16 * $urandom_range(1, 4);
            rl = $urandom_range(1, 120);
            n = $urandom_range(40, 120);
            case ($urandom_range(0, 9))
                0: rl = 0;
                1: begin
                    rl = 65535;
                    gs = 256;
                    n = 40;
                end
                2: begin
                    gs = $urandom_range(0, 1) ? 32'd256 : 32'd511;
                    rl = $urandom_range(256, 600);
                end
                3: gs = $urandom_range(0, 15);
                4: gs = $urandom_range(0, 511);
                default: ;
            endcase
            if (phase == 1) begin
                rl = 1;
                n = 60;
            end
            sr = $urandom_range(0, 65535);
            case ($urandom_range(0, 4))
                0:       er = 65536;
                1:       er = $urandom_range(0, 1) ? 32'd0 : sr;
                2:       er = $urandom_range(0, 131071);
                default: er = sr + $urandom_range(1, 5);
            endcase
            set_job(rl, gs, sr, er);
            if (phase == 1)
                hold_req = 1'b1;
            repeat (n) offer(rand_item(), 1'b0, none);
            phase++;
        end
        in_valid <= 1'b0;

        wait (expected_rows.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("q8_group_quantized_matvec_unit_tb: done, clean");
        else
            $display("q8_group_quantized_matvec_unit_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
